// File: hw/rtl/mcm_pkg.sv
// Shared types and constants for the 4x4 column multiply block.
package mcm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ELEM_W    = 32;
	localparam int DIM       = 4;
	localparam int PROD_W    = 2 * ELEM_W;
	localparam int PAIR_W    = PROD_W + 1;
	localparam int SUM_W     = PROD_W + 2;
	localparam int SHF_W     = SUM_W - FRAC_BITS;

	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_MULTIPLY = 1'b1;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef elem_t vec4_t [DIM];

	localparam elem_t ONE_Q = elem_t'({{(ELEM_W-1){1'b0}}, 1'b1} << FRAC_BITS);
	localparam elem_t MAX_Q = {1'b0, {(ELEM_W-1){1'b1}}};
	localparam elem_t MIN_Q = {1'b1, {(ELEM_W-1){1'b0}}};

	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
	} pipe_ctl_t;

endpackage

// File: hw/rtl/mcm_lane.sv
// One row lane: four products, a two-level adder, floor shift and saturation.
module mcm_lane (
	input  logic               clk,
	input  mcm_pkg::pipe_ctl_t ctl,
	input  mcm_pkg::vec4_t     a,
	input  mcm_pkg::vec4_t     b,
	output mcm_pkg::elem_t     c,
	output logic               clip
);

	logic signed [mcm_pkg::PROD_W-1:0] prod_s1 [mcm_pkg::DIM];
	logic signed [mcm_pkg::PAIR_W-1:0] pair_s2 [2];
	logic signed [mcm_pkg::SUM_W-1:0]  sum;
	logic        [mcm_pkg::SHF_W-1:0]  shifted;
	logic                              fits;
	mcm_pkg::elem_t                    c_s3;
	logic                              clip_s3;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			for (int k = 0; k < mcm_pkg::DIM; k++) begin
				prod_s1[k] <= $signed(a[k]) * $signed(b[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			pair_s2[0] <= mcm_pkg::PAIR_W'(prod_s1[0]) + mcm_pkg::PAIR_W'(prod_s1[1]);
			pair_s2[1] <= mcm_pkg::PAIR_W'(prod_s1[2]) + mcm_pkg::PAIR_W'(prod_s1[3]);
		end
	end

	// floor by dropping fraction bits, then check the upper bits fit the element
	always_comb begin
		sum     = mcm_pkg::SUM_W'(pair_s2[0]) + mcm_pkg::SUM_W'(pair_s2[1]);
		shifted = sum[mcm_pkg::SUM_W-1:mcm_pkg::FRAC_BITS];
		fits    = (&shifted[mcm_pkg::SHF_W-1:mcm_pkg::ELEM_W-1]) ||
		          !(|shifted[mcm_pkg::SHF_W-1:mcm_pkg::ELEM_W-1]);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			clip_s3 <= !fits;
			if (fits) begin
				c_s3 <= shifted[mcm_pkg::ELEM_W-1:0];
			end else if (shifted[mcm_pkg::SHF_W-1]) begin
				c_s3 <= mcm_pkg::MIN_Q;
			end else begin
				c_s3 <= mcm_pkg::MAX_Q;
			end
		end
	end

	assign c    = c_s3;
	assign clip = clip_s3;

endmodule

// File: hw/rtl/mcm_merge.sv
// Output register that gathers the four lane results and merges their clip flags.
module mcm_merge (
	input  logic                      clk,
	input  logic                      ld,
	input  logic [1:0]                col,
	input  mcm_pkg::vec4_t            c,
	input  logic [mcm_pkg::DIM-1:0]   clip,
	output logic [1:0]                out_column,
	output mcm_pkg::vec4_t            c_out,
	output logic                      saturated
);

	logic [1:0]     col_q;
	mcm_pkg::vec4_t c_q;
	logic           sat_q;

	always_ff @(posedge clk) begin
		if (ld) begin
			col_q <= col;
			c_q   <= c;
			sat_q <= |clip;
		end
	end

	assign out_column = col_q;
	assign c_out      = c_q;
	assign saturated  = sat_q;

endmodule

// File: hw/rtl/matrix4x4_column_multiply.sv
// Top level of the 4x4 column-major Q16.16 matrix-by-column multiplier.
// Takes one transaction per cycle while in_stall is low. A load transaction writes
// one element of the held matrix (reset value: identity) and returns nothing; it
// takes effect for every multiply accepted after it. A multiply transaction raises
// out_valid with its product column at the end of the pipeline: four row lanes each
// run one multiplier stage, two adder stages (pair sums, then final sum with floor
// shift and saturation), and a shared output register merges the lanes and their
// clip flags. Each stage holds its contents only while the stage after it is full
// and stalled, so bubbles collapse; input stalls only once every stage behind a
// waiting result is full.
module matrix4x4_column_multiply (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 op,
	input  logic [3:0]           load_index,
	input  mcm_pkg::elem_t       load_value,
	input  logic [1:0]           column_tag,
	input  mcm_pkg::elem_t       b_row0,
	input  mcm_pkg::elem_t       b_row1,
	input  mcm_pkg::elem_t       b_row2,
	input  mcm_pkg::elem_t       b_row3,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           out_column,
	output mcm_pkg::elem_t       c_row0,
	output mcm_pkg::elem_t       c_row1,
	output mcm_pkg::elem_t       c_row2,
	output mcm_pkg::elem_t       c_row3,
	output logic                 saturated
);

	mcm_pkg::elem_t     held_q [16];
	mcm_pkg::vec4_t     b_vec;
	mcm_pkg::vec4_t     c_vec;
	mcm_pkg::vec4_t     c_out;
	logic [mcm_pkg::DIM-1:0] clip;
	mcm_pkg::pipe_ctl_t ctl;
	logic               v_s1, v_s2, v_s3, out_valid_q;
	logic               rdy1, rdy2, rdy3, rdy_out;
	logic               in_acc;
	logic [1:0]         col_s1, col_s2, col_s3;

	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy3    = !v_s3 || rdy_out;
	assign rdy2    = !v_s2 || rdy3;
	assign rdy1    = !v_s1 || rdy2;
	assign in_stall = !rdy1;
	assign in_acc   = in_valid && rdy1;

	assign ctl.ld_s1 = rdy1;
	assign ctl.ld_s2 = rdy2;
	assign ctl.ld_s3 = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_acc && (op == mcm_pkg::OP_MULTIPLY);
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				held_q[i] <= (i % 5 == 0) ? mcm_pkg::ONE_Q : '0;
			end
		end else if (in_acc && (op == mcm_pkg::OP_LOAD)) begin
			held_q[load_index] <= load_value;
		end
	end

	// column tag rides alongside the lanes
	always_ff @(posedge clk) begin
		if (rdy1) begin
			col_s1 <= column_tag;
		end
		if (rdy2) begin
			col_s2 <= col_s1;
		end
		if (rdy3) begin
			col_s3 <= col_s2;
		end
	end

	assign b_vec[0] = b_row0;
	assign b_vec[1] = b_row1;
	assign b_vec[2] = b_row2;
	assign b_vec[3] = b_row3;

	for (genvar r = 0; r < mcm_pkg::DIM; r++) begin : g_lane
		mcm_pkg::vec4_t a_row;

		for (genvar k = 0; k < mcm_pkg::DIM; k++) begin : g_tap
			assign a_row[k] = held_q[k * mcm_pkg::DIM + r];
		end

		mcm_lane u_lane (
			.clk  (clk),
			.ctl  (ctl),
			.a    (a_row),
			.b    (b_vec),
			.c    (c_vec[r]),
			.clip (clip[r])
		);
	end

	mcm_merge u_merge (
		.clk        (clk),
		.ld         (rdy_out),
		.col        (col_s3),
		.c          (c_vec),
		.clip       (clip),
		.out_column (out_column),
		.c_out      (c_out),
		.saturated  (saturated)
	);

	assign out_valid = out_valid_q;
	assign c_row0    = c_out[0];
	assign c_row1    = c_out[1];
	assign c_row2    = c_out[2];
	assign c_row3    = c_out[3];

endmodule
